@@ src/qrm_pkg.sv @@
// Shared types, constants and arithmetic helpers for the quaternion to
// rotation matrix pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qrm_pkg;

    // Signed 4.12 fixed point word
    typedef logic signed [15:0] t_fx;

    localparam int FRAC_BITS = 12;
    localparam int FX_W      = 16;
    localparam int PROD_W    = 2 * FX_W;

    // 1.0 in 4.12
    localparam t_fx ONE_RAW = t_fx'(1 << FRAC_BITS);

    // Nine pairwise products of the quaternion components
    typedef struct packed {
        t_fx xx;
        t_fx yy;
        t_fx zz;
        t_fx xy;
        t_fx xz;
        t_fx yz;
        t_fx wx;
        t_fx wy;
        t_fx wz;
    } t_prod;

    // Sums of squares and combined cross products, before doubling
    typedef struct packed {
        t_fx s_yz;   // yy + zz
        t_fx s_xz;   // xx + zz
        t_fx s_xy;   // xx + yy
        t_fx c01;    // xy - wz
        t_fx c02;    // xz + wy
        t_fx c10;    // xy + wz
        t_fx c12;    // yz - wx
        t_fx c20;    // xz - wy
        t_fx c21;    // yz + wx
    } t_sum;

    // Full signed product, arithmetic shift by FRAC_BITS (floor), wrapped to 16 bits
    function automatic t_fx fx_mul(input t_fx a, input t_fx b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return p[FRAC_BITS +: FX_W];
    endfunction

    // Multiply by two with wrap
    function automatic t_fx fx_dbl(input t_fx v);
        return {v[FX_W-2:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ src/quaternion_to_rotation_matrix_top.sv @@
// Top level: quaternion (4.12) to 3x3 rotation matrix (4.12), three stage pipeline.
// Depends on qrm_pkg and qrm_products.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one quaternion per clock cycle: busy is always low, so a transaction is
// taken at every edge where start is high. The matrix appears on the o_m* ports
// once it has passed through the product, sum and matrix registers in turn, and
// stays for one cycle, flagged by o_valid; the receiver cannot stall it. The
// three register stages are the nine 16x16 products, the pairwise sums and
// differences, and the doubling with subtraction from one. No normalization is
// done and all arithmetic wraps to 16 bits; products round toward minus
// infinity.
module quaternion_to_rotation_matrix_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire qrm_pkg::t_fx i_quat_x,
    input  wire qrm_pkg::t_fx i_quat_y,
    input  wire qrm_pkg::t_fx i_quat_z,
    input  wire qrm_pkg::t_fx i_quat_w,
    output logic              o_valid,
    output qrm_pkg::t_fx      o_m00,
    output qrm_pkg::t_fx      o_m01,
    output qrm_pkg::t_fx      o_m02,
    output qrm_pkg::t_fx      o_m10,
    output qrm_pkg::t_fx      o_m11,
    output qrm_pkg::t_fx      o_m12,
    output qrm_pkg::t_fx      o_m20,
    output qrm_pkg::t_fx      o_m21,
    output qrm_pkg::t_fx      o_m22
);
    import qrm_pkg::*;

    logic  s1_valid;
    t_prod s1_prod;

    logic  r_s2_valid;
    t_sum  r_sum;
    t_sum  n_sum;

    logic  r_s3_valid;
    t_fx   r_m00, r_m01, r_m02, r_m10, r_m11, r_m12, r_m20, r_m21, r_m22;

    // The pipeline never stalls
    assign busy = 1'b0;

    // Stage 1: products
    qrm_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .i_w     (i_quat_w),
        .o_valid (s1_valid),
        .o_prod  (s1_prod)
    );

    // Stage 2: combine squares and cross products, wrapping in 16 bits
    always_comb begin
        n_sum.s_yz = t_fx'(s1_prod.yy + s1_prod.zz);
        n_sum.s_xz = t_fx'(s1_prod.xx + s1_prod.zz);
        n_sum.s_xy = t_fx'(s1_prod.xx + s1_prod.yy);
        n_sum.c01  = t_fx'(s1_prod.xy - s1_prod.wz);
        n_sum.c02  = t_fx'(s1_prod.xz + s1_prod.wy);
        n_sum.c10  = t_fx'(s1_prod.xy + s1_prod.wz);
        n_sum.c12  = t_fx'(s1_prod.yz - s1_prod.wx);
        n_sum.c20  = t_fx'(s1_prod.xz - s1_prod.wy);
        n_sum.c21  = t_fx'(s1_prod.yz + s1_prod.wx);
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // Stage 3: double, and subtract from one on the diagonal
    always_ff @(posedge i_clk) begin
        r_m00 <= t_fx'(ONE_RAW - fx_dbl(r_sum.s_yz));
        r_m11 <= t_fx'(ONE_RAW - fx_dbl(r_sum.s_xz));
        r_m22 <= t_fx'(ONE_RAW - fx_dbl(r_sum.s_xy));
        r_m01 <= fx_dbl(r_sum.c01);
        r_m02 <= fx_dbl(r_sum.c02);
        r_m10 <= fx_dbl(r_sum.c10);
        r_m12 <= fx_dbl(r_sum.c12);
        r_m20 <= fx_dbl(r_sum.c20);
        r_m21 <= fx_dbl(r_sum.c21);
    end

    // Advance valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_m00   = r_m00;
    assign o_m01   = r_m01;
    assign o_m02   = r_m02;
    assign o_m10   = r_m10;
    assign o_m11   = r_m11;
    assign o_m12   = r_m12;
    assign o_m20   = r_m20;
    assign o_m21   = r_m21;
    assign o_m22   = r_m22;

endmodule

`default_nettype wire

@@ src/qrm_products.sv @@
// First pipeline stage: the nine pairwise fixed point products, registered.
// Depends on qrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrm_products (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire qrm_pkg::t_fx i_x,
    input  wire qrm_pkg::t_fx i_y,
    input  wire qrm_pkg::t_fx i_z,
    input  wire qrm_pkg::t_fx i_w,
    output logic              o_valid,
    output qrm_pkg::t_prod    o_prod
);
    import qrm_pkg::*;

    logic  r_valid;
    t_prod r_prod;
    t_prod n_prod;

    // Form all nine products in parallel
    always_comb begin
        n_prod.xx = fx_mul(i_x, i_x);
        n_prod.yy = fx_mul(i_y, i_y);
        n_prod.zz = fx_mul(i_z, i_z);
        n_prod.xy = fx_mul(i_x, i_y);
        n_prod.xz = fx_mul(i_x, i_z);
        n_prod.yz = fx_mul(i_y, i_z);
        n_prod.wx = fx_mul(i_w, i_x);
        n_prod.wy = fx_mul(i_w, i_y);
        n_prod.wz = fx_mul(i_w, i_z);
    end

    // Advance valid bit; clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Capture products
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

@@ src/qrm_checker.sv @@
// Port level checks for the quaternion to rotation matrix pipeline, bound to
// the top level. Depends on qrm_pkg and quaternion_to_rotation_matrix_top.
`timescale 1ns / 1ps
`default_nettype none

module qrm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire qrm_pkg::t_fx i_quat_x,
    input wire qrm_pkg::t_fx i_quat_y,
    input wire qrm_pkg::t_fx i_quat_z,
    input wire logic         o_valid,
    input wire qrm_pkg::t_fx o_m00,
    input wire qrm_pkg::t_fx o_m01,
    input wire qrm_pkg::t_fx o_m02,
    input wire qrm_pkg::t_fx o_m10,
    input wire qrm_pkg::t_fx o_m11,
    input wire qrm_pkg::t_fx o_m12,
    input wire qrm_pkg::t_fx o_m20,
    input wire qrm_pkg::t_fx o_m21,
    input wire qrm_pkg::t_fx o_m22
);
    import qrm_pkg::*;

    // Every transaction is taken
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // A result only ever follows an accepted transaction
    a_result_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result without matching transaction");

    // Every entry is doubled, or one minus a doubled value, so its lowest bit is clear
    a_entries_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_m00[0] | o_m01[0] | o_m02[0] | o_m10[0] | o_m11[0]
                      | o_m12[0] | o_m20[0] | o_m21[0] | o_m22[0]))
        else $error("odd matrix entry");

    // A zero vector part gives the identity matrix whatever w is
    a_zero_vector_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_quat_x, 3) == '0 && $past(i_quat_y, 3) == '0
                 && $past(i_quat_z, 3) == '0)
        |-> (o_m00 == ONE_RAW && o_m11 == ONE_RAW && o_m22 == ONE_RAW
             && o_m01 == '0 && o_m02 == '0 && o_m10 == '0
             && o_m12 == '0 && o_m20 == '0 && o_m21 == '0))
        else $error("zero vector part did not give identity");

endmodule

bind quaternion_to_rotation_matrix_top qrm_checker u_qrm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_quat_x (i_quat_x),
    .i_quat_y (i_quat_y),
    .i_quat_z (i_quat_z),
    .o_valid  (o_valid),
    .o_m00    (o_m00),
    .o_m01    (o_m01),
    .o_m02    (o_m02),
    .o_m10    (o_m10),
    .o_m11    (o_m11),
    .o_m12    (o_m12),
    .o_m20    (o_m20),
    .o_m21    (o_m21),
    .o_m22    (o_m22)
);

`default_nettype wire
